/* hdl/fale_pkg.sv */
// shared types and constants of the fixed array list engine
package fale_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 4;
    localparam int VAL_W    = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 3;
    localparam int STAT_W   = 3;
    localparam int IN_W     = 40;
    localparam int IN_USER_W = 8;
    localparam int OUT_W    = 112;
    localparam int OUT_USED = VAL_W + STAT_W + CNT_W + 2 + 2 * VAL_W;
    localparam int OUT_PAD  = OUT_W - OUT_USED;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_DEL_FRONT = 3'd2,
        MODE_DEL_BACK  = 3'd3,
        MODE_DEDUP     = 3'd4,
        MODE_READ_POS  = 3'd5,
        MODE_SUCC      = 3'd6,
        MODE_PRED      = 3'd7
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_BAD_POS  = 3'd3,
        STAT_NOT_FND  = 3'd4,
        STAT_NO_NEIGH = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_SHR_RD,
        FSM_SHR_WR,
        FSM_SHL_RD,
        FSM_SHL_WR,
        FSM_DD_RD,
        FSM_DD_CUR,
        FSM_DD_IN_RD,
        FSM_DD_IN_CMP,
        FSM_SR_RD,
        FSM_SR_CMP,
        FSM_RD_CAP,
        FSM_FIRST,
        FSM_LAST,
        FSM_LAST_CAP,
        FSM_DONE
    } fsm_state_t;

endpackage

/* hdl/fixed_array_list_engine.sv */
// fixed array list engine: ordered list of signed words under a small sequencer
//
//   s_ channel takes one command word; s_tuser holds the mode, s_tdata the
//   value and the position. m_ channel returns one result word per command.
//   s_tready is high only while the sequencer is idle; one command at a time.
//   entries live in a memory with one read and one write port and a registered
//   read. insert front and remove front shift the entries by one place;
//   successor and predecessor scan from the front for the first match; dedup
//   keeps each entry that is not already among the kept ones, in order.
//   the closing reads of the front and back entries are skipped on an empty list.
//   reset clears the count, the sequencer and the result valid; entry contents are not cleared.
//   a stalled result holds on m_ until taken; the finished next command waits
//   in the sequencer until the output register is free.
module fixed_array_list_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // value [31:0], position [34:32], zero fill
    input  logic [fale_pkg::IN_W-1:0]   s_tdata,
    // mode [2:0], zero fill
    input  logic [fale_pkg::IN_USER_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // data_out [31:0], status [34:32], count [38:35], is_empty [39],
    // is_full [40], first_value [72:41], last_value [104:73], zero fill
    output logic [fale_pkg::OUT_W-1:0]  m_tdata
);
    import fale_pkg::*;

    logic signed [VAL_W-1:0] mem [CAPACITY];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    fsm_state_t              state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        jdx_reg, jdx_next;
    logic [CNT_W-1:0]        kept_reg, kept_next;
    status_t                 status_reg, status_next;
    logic signed [VAL_W-1:0] data_reg, data_next;
    logic signed [VAL_W-1:0] first_reg, first_next;
    logic signed [VAL_W-1:0] last_reg, last_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic signed [VAL_W-1:0] m_data_reg, m_data_next;
    status_t                 m_status_reg, m_status_next;
    logic [CNT_W-1:0]        m_count_reg, m_count_next;
    logic                    m_empty_reg, m_empty_next;
    logic                    m_full_reg, m_full_next;
    logic signed [VAL_W-1:0] m_first_reg, m_first_next;
    logic signed [VAL_W-1:0] m_last_reg, m_last_next;

    logic [CNT_W-1:0]        idx_inc, idx_dec, cnt_inc, cnt_dec, kept_inc, jdx_inc;
    logic                    val_eq;
    logic                    in_accept;
    logic                    list_full, list_empty;

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign cnt_inc    = count_reg + CNT_W'(1);
    assign cnt_dec    = count_reg - CNT_W'(1);
    assign kept_inc   = kept_reg + CNT_W'(1);
    assign jdx_inc    = jdx_reg + CNT_W'(1);
    // shared compare unit
    assign val_eq     = (rd_data_reg == val_reg);
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);

    assign s_tready  = (state_reg == FSM_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, m_last_reg, m_first_reg, m_full_reg, m_empty_reg,
                       m_count_reg, m_status_reg, m_data_reg};

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        jdx_reg      <= jdx_next;
        kept_reg     <= kept_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_empty_reg  <= m_empty_next;
        m_full_reg   <= m_full_next;
        m_first_reg  <= m_first_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        jdx_next      = jdx_reg;
        kept_next     = kept_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;
        m_full_next   = m_full_reg;
        m_first_next  = m_first_reg;
        m_last_next   = m_last_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = val_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (in_accept) begin
                    mode_next   = mode_t'(s_tuser[MODE_W-1:0]);
                    val_next    = s_tdata[VAL_W-1:0];
                    pos_next    = s_tdata[VAL_W+POS_W-1:VAL_W];
                    status_next = STAT_OK;
                    data_next   = '0;
                    idx_next    = '0;
                    kept_next   = '0;
                    state_next  = FSM_FIRST;
                    unique case (mode_t'(s_tuser[MODE_W-1:0]))
                        MODE_INS_FRONT: begin
                            if (list_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                idx_next   = count_reg;
                                state_next = FSM_SHR_RD;
                            end
                        end
                        MODE_INS_BACK: begin
                            if (list_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = s_tdata[VAL_W-1:0];
                                count_next = cnt_inc;
                            end
                        end
                        MODE_DEL_FRONT: begin
                            if (list_empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                state_next = FSM_SHL_RD;
                            end
                        end
                        MODE_DEL_BACK: begin
                            if (list_empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                count_next = cnt_dec;
                            end
                        end
                        MODE_DEDUP: begin
                            state_next = FSM_DD_RD;
                        end
                        MODE_READ_POS: begin
                            if (CNT_W'(s_tdata[VAL_W+POS_W-1:VAL_W]) >= count_reg) begin
                                status_next = STAT_BAD_POS;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = s_tdata[VAL_W+POS_W-1:VAL_W];
                                state_next = FSM_RD_CAP;
                            end
                        end
                        MODE_SUCC, MODE_PRED: begin
                            state_next = FSM_SR_RD;
                        end
                        default: begin
                            state_next = FSM_FIRST;
                        end
                    endcase
                end
            end
            FSM_SHR_RD: begin
                if (idx_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = cnt_inc;
                    state_next = FSM_FIRST;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[IDX_W-1:0];
                    state_next = FSM_SHR_WR;
                end
            end
            FSM_SHR_WR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[IDX_W-1:0];
                wr_data    = rd_data_reg;
                idx_next   = idx_dec;
                state_next = FSM_SHR_RD;
            end
            FSM_SHL_RD: begin
                if (idx_inc >= count_reg) begin
                    count_next = cnt_dec;
                    state_next = FSM_FIRST;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[IDX_W-1:0];
                    state_next = FSM_SHL_WR;
                end
            end
            FSM_SHL_WR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[IDX_W-1:0];
                wr_data    = rd_data_reg;
                idx_next   = idx_inc;
                state_next = FSM_SHL_RD;
            end
            FSM_DD_RD: begin
                if (idx_reg >= count_reg) begin
                    count_next = kept_reg;
                    state_next = FSM_FIRST;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[IDX_W-1:0];
                    state_next = FSM_DD_CUR;
                end
            end
            FSM_DD_CUR: begin
                val_next   = rd_data_reg;
                jdx_next   = '0;
                state_next = FSM_DD_IN_RD;
            end
            FSM_DD_IN_RD: begin
                if (jdx_reg >= kept_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = kept_reg[IDX_W-1:0];
                    kept_next  = kept_inc;
                    idx_next   = idx_inc;
                    state_next = FSM_DD_RD;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = jdx_reg[IDX_W-1:0];
                    state_next = FSM_DD_IN_CMP;
                end
            end
            FSM_DD_IN_CMP: begin
                if (val_eq) begin
                    idx_next   = idx_inc;
                    state_next = FSM_DD_RD;
                end else begin
                    jdx_next   = jdx_inc;
                    state_next = FSM_DD_IN_RD;
                end
            end
            FSM_SR_RD: begin
                if (idx_reg >= count_reg) begin
                    status_next = STAT_NOT_FND;
                    state_next  = FSM_FIRST;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[IDX_W-1:0];
                    state_next = FSM_SR_CMP;
                end
            end
            FSM_SR_CMP: begin
                if (!val_eq) begin
                    idx_next   = idx_inc;
                    state_next = FSM_SR_RD;
                end else if (mode_reg == MODE_SUCC) begin
                    if (idx_inc >= count_reg) begin
                        status_next = STAT_NO_NEIGH;
                        state_next  = FSM_FIRST;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_inc[IDX_W-1:0];
                        state_next = FSM_RD_CAP;
                    end
                end else begin
                    if (idx_reg == '0) begin
                        status_next = STAT_NO_NEIGH;
                        state_next  = FSM_FIRST;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_dec[IDX_W-1:0];
                        state_next = FSM_RD_CAP;
                    end
                end
            end
            FSM_RD_CAP: begin
                data_next  = rd_data_reg;
                state_next = FSM_FIRST;
            end
            FSM_FIRST: begin
                if (list_empty) begin
                    first_next = '0;
                    last_next  = '0;
                    state_next = FSM_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = FSM_LAST;
                end
            end
            FSM_LAST: begin
                first_next = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = cnt_dec[IDX_W-1:0];
                state_next = FSM_LAST_CAP;
            end
            FSM_LAST_CAP: begin
                last_next  = rd_data_reg;
                state_next = FSM_DONE;
            end
            FSM_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = data_reg;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                    m_empty_next  = list_empty;
                    m_full_next   = list_full;
                    m_first_next  = first_reg;
                    m_last_next   = last_reg;
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

/* hdl/fale_checker.sv */
// port-level checks of the fixed array list engine and their bind
module fale_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fale_pkg::OUT_W-1:0]    m_tdata
);
    import fale_pkg::*;

    logic [CNT_W-1:0] res_count;
    logic             res_empty;
    logic             res_full;
    logic [STAT_W-1:0] res_status;

    assign res_status = m_tdata[VAL_W+STAT_W-1:VAL_W];
    assign res_count  = m_tdata[VAL_W+STAT_W+CNT_W-1:VAL_W+STAT_W];
    assign res_empty  = m_tdata[VAL_W+STAT_W+CNT_W];
    assign res_full   = m_tdata[VAL_W+STAT_W+CNT_W+1];

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one command at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command word taken while busy");

    // fill flags agree with the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_empty == (res_count == '0))
                  && (res_full == (res_count == CNT_W'(CAPACITY))))
        else $error("fill flags disagree with count");

    // empty list shows zero front and back entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_empty |-> m_tdata[OUT_USED-1:VAL_W+STAT_W+CNT_W+2] == '0)
        else $error("empty list with nonzero front or back entry");

    // failed commands return zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status != STAT_OK |-> m_tdata[VAL_W-1:0] == '0)
        else $error("nonzero data on failed command");

endmodule

bind fixed_array_list_engine fale_checker u_fale_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
